FILE: rtl/core/axof_pkg.sv
// ----------------------------------------------------------------------------
// Ascon-XOF128 sponge package
// Constants shared by the sponge core and its checker, and the types and
// single-round permutation function used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package axof_pkg;

    localparam int unsigned ROUNDS           = 12;
    localparam int unsigned MAX_OUTPUT_BYTES = 512;
    localparam int unsigned LEN_W            = 10;
    localparam int unsigned ROUND_W          = 4;
    localparam int unsigned BYTES_W          = 4;

    localparam logic [63:0]      XOF_IV        = 64'h0000_0800_00CC_0003;
    localparam logic [LEN_W-1:0] LEN_RESET     = LEN_W'(32);
    localparam logic [LEN_W-1:0] LEN_MAX       = LEN_W'(MAX_OUTPUT_BYTES);
    localparam logic [BYTES_W-1:0] FULL_BYTES  = BYTES_W'(8);

    typedef logic [63:0]      word_t;
    typedef word_t [4:0]      sponge_t;

    // Word 0 holds the IV, the others are zero.
    localparam sponge_t IV_STATE = {64'd0, 64'd0, 64'd0, 64'd0, XOF_IV};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ABSORB,
        ST_OUT,
        ST_SQUEEZE
    } state_t;

    // Round constants run 0xf0, 0xe1, ... 0x4b: high nibble counts down, low up.
    function automatic logic [7:0] round_const(input logic [ROUND_W-1:0] r);
        return {4'(4'd15 - r), r};
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Mask that keeps bytes below n; n of eight or more keeps all bytes.
    function automatic word_t byte_mask(input logic [BYTES_W-1:0] n);
        word_t m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (BYTES_W'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Padding byte 0x01 placed at byte n, for n below eight.
    function automatic word_t pad_word(input logic [BYTES_W-1:0] n);
        word_t p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (BYTES_W'(i) == n) begin
                p[8*i] = 1'b1;
            end
        end
        return p;
    endfunction

    // One Ascon round: constant addition, S-box layer, linear layer.
    function automatic sponge_t perm_round(input sponge_t s, input logic [7:0] rc);
        word_t x0, x1, x2, x3, x4;
        word_t t0, t1, t2, t3, t4;
        sponge_t r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, rc};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
        r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ascon_xof128_sponge_top.sv
// ----------------------------------------------------------------------------
// Ascon-XOF128 sponge
// Absorbs 64-bit message blocks and squeezes a configurable number of output
// bytes, using one shared permutation round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes message blocks (s_block_data, s_block_bytes,
//   s_last_block). Non-last blocks always absorb all eight bytes; the last
//   block is masked to s_block_bytes and padded. The m_ channel returns the
//   output in 8-byte blocks, m_out_last marking the final one. The cfg_
//   channel writes the output length in bytes (saturated to 512) and should
//   only be used while the block is idle; cfg_ready is always high.
// Timing:
//   One round of the permutation runs per cycle; P12 is 12 rounds. A
//   block is taken in IDLE and then runs the 12 rounds. A full
//   last block adds a padded empty block for another 12 rounds. Each output
//   block is offered as soon as its permutation ends; between output blocks
//   12 rounds run. After the final output block (or right after the last
//   input block when the length is zero) the state is re-initialized by
//   running the 12 rounds on the IV before s_ready returns.
// Reset and stalls:
//   After reset the IV is permuted for 12 rounds before the first transfer.
//   While the receiver stalls, the output block holds and no input is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_xof128_sponge_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [axof_pkg::LEN_W-1:0]    cfg_output_length,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [63:0]                   s_block_data,
    input  wire logic [axof_pkg::BYTES_W-1:0]  s_block_bytes,
    input  wire logic                          s_last_block,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [63:0]                        m_out_data,
    output logic [axof_pkg::BYTES_W-1:0]       m_out_bytes,
    output logic                               m_out_last
);

    axof_pkg::state_t                  state_reg, state_next;
    axof_pkg::sponge_t                 sponge_reg, sponge_next;
    logic [axof_pkg::ROUND_W-1:0]      round_reg, round_next;
    logic [axof_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [axof_pkg::LEN_W-1:0]        remain_reg, remain_next;
    logic                              pad_reg, pad_next;
    logic                              squeeze_reg, squeeze_next;

    axof_pkg::sponge_t                 round_out;
    axof_pkg::word_t                   absorb_word;
    logic [axof_pkg::LEN_W-1:0]        len_sat;
    logic [axof_pkg::BYTES_W-1:0]      take;
    logic                              round_done;
    logic                              final_out;
    logic                              in_xfer;
    logic                              out_xfer;

    assign round_out  = axof_pkg::perm_round(sponge_reg, axof_pkg::round_const(round_reg));
    assign round_done = (round_reg == axof_pkg::ROUND_W'(axof_pkg::ROUNDS - 1));
    assign len_sat    = (len_reg > axof_pkg::LEN_MAX) ? axof_pkg::LEN_MAX : len_reg;
    assign take       = (remain_reg > axof_pkg::LEN_W'(8)) ? axof_pkg::FULL_BYTES
                                                           : remain_reg[axof_pkg::BYTES_W-1:0];
    assign final_out  = (remain_reg <= axof_pkg::LEN_W'(8));
    assign in_xfer    = s_valid && s_ready;
    assign out_xfer   = m_valid && m_ready;

    // A full last block absorbs as is; the padding goes into the block after.
    always_comb begin
        if (!s_last_block || s_block_bytes >= axof_pkg::FULL_BYTES) begin
            absorb_word = s_block_data;
        end else begin
            absorb_word = (s_block_data & axof_pkg::byte_mask(s_block_bytes))
                          ^ axof_pkg::pad_word(s_block_bytes);
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            axof_pkg::ST_INIT: begin
                if (round_done) begin
                    state_next = axof_pkg::ST_IDLE;
                end
            end
            axof_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = axof_pkg::ST_ABSORB;
                end
            end
            axof_pkg::ST_ABSORB: begin
                if (round_done && !pad_reg) begin
                    if (!squeeze_reg) begin
                        state_next = axof_pkg::ST_IDLE;
                    end else if (len_sat == '0) begin
                        state_next = axof_pkg::ST_INIT;
                    end else begin
                        state_next = axof_pkg::ST_OUT;
                    end
                end
            end
            axof_pkg::ST_OUT: begin
                if (out_xfer) begin
                    state_next = final_out ? axof_pkg::ST_INIT : axof_pkg::ST_SQUEEZE;
                end
            end
            axof_pkg::ST_SQUEEZE: begin
                if (round_done) begin
                    state_next = axof_pkg::ST_OUT;
                end
            end
            default: begin
                state_next = axof_pkg::ST_INIT;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            axof_pkg::ST_IDLE: s_ready = 1'b1;
            axof_pkg::ST_OUT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign cfg_ready   = 1'b1;
    assign m_out_data  = sponge_reg[0] & axof_pkg::byte_mask(take);
    assign m_out_bytes = take;
    assign m_out_last  = final_out;

    // Datapath next values.
    always_comb begin
        sponge_next  = sponge_reg;
        round_next   = round_reg;
        remain_next  = remain_reg;
        pad_next     = pad_reg;
        squeeze_next = squeeze_reg;
        len_next     = (cfg_valid && cfg_ready) ? cfg_output_length : len_reg;
        case (state_reg) inside
            axof_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    sponge_next[0] = sponge_reg[0] ^ absorb_word;
                    round_next     = '0;
                    pad_next       = s_last_block && (s_block_bytes >= axof_pkg::FULL_BYTES);
                    squeeze_next   = s_last_block;
                end
            end
            axof_pkg::ST_INIT, axof_pkg::ST_ABSORB, axof_pkg::ST_SQUEEZE: begin
                sponge_next = round_out;
                round_next  = round_reg + axof_pkg::ROUND_W'(1);
                if (round_done) begin
                    round_next = '0;
                    if (state_reg == axof_pkg::ST_ABSORB) begin
                        if (pad_reg) begin
                            // Padded empty block after a full last block.
                            sponge_next[0] = round_out[0] ^ 64'd1;
                            pad_next       = 1'b0;
                        end else if (squeeze_reg) begin
                            squeeze_next = 1'b0;
                            remain_next  = len_sat;
                            if (len_sat == '0) begin
                                sponge_next = axof_pkg::IV_STATE;
                            end
                        end
                    end
                end
            end
            axof_pkg::ST_OUT: begin
                if (out_xfer) begin
                    remain_next = remain_reg - axof_pkg::LEN_W'(take);
                    round_next  = '0;
                    if (final_out) begin
                        sponge_next = axof_pkg::IV_STATE;
                    end
                end
            end
            default: begin
                sponge_next = sponge_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= axof_pkg::ST_INIT;
            sponge_reg  <= axof_pkg::IV_STATE;
            round_reg   <= '0;
            len_reg     <= axof_pkg::LEN_RESET;
            remain_reg  <= '0;
            pad_reg     <= 1'b0;
            squeeze_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sponge_reg  <= sponge_next;
            round_reg   <= round_next;
            len_reg     <= len_next;
            remain_reg  <= remain_next;
            pad_reg     <= pad_next;
            squeeze_reg <= squeeze_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/axof_checker.sv
// ----------------------------------------------------------------------------
// Ascon-XOF128 sponge port checker
// Watches the top-level ports and flags sequencing and output-shape errors.
// ----------------------------------------------------------------------------
`default_nettype none

module axof_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [63:0]                   m_out_data,
    input wire logic [axof_pkg::BYTES_W-1:0]  m_out_bytes,
    input wire logic                          m_out_last
);

    // The core works on one message block at a time.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input ready while an output block is pending");

    // A stalled output block holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_out_data) && $stable(m_out_bytes) && $stable(m_out_last)))
        else $error("output block changed while stalled");

    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_bytes != '0 && m_out_bytes <= axof_pkg::FULL_BYTES))
        else $error("output byte count out of range");

    // Only the final output block may be short.
    a_full_until_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_last) |-> (m_out_bytes == axof_pkg::FULL_BYTES))
        else $error("short output block before the last one");

    // After the final output transfer the state is re-initialized first.
    a_reinit_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_out_last) |=> !s_ready)
        else $error("input accepted before re-initialization");

endmodule

bind ascon_xof128_sponge_top axof_checker u_axof_checker (.*);

`default_nettype wire
